// ===== hw/rtl/gauss_seidel_linear_solver_top_defines.svh =====
// Assertion macros for the solver's port checker.
// No dependencies.
`ifndef GAUSS_SEIDEL_LINEAR_SOLVER_TOP_DEFINES_SVH
`define GAUSS_SEIDEL_LINEAR_SOLVER_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define GS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define GS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/gsls_pkg.sv =====
// Shared types and constants of the Gauss-Seidel solver.
// No dependencies.
package gsls_pkg;
  localparam int MAX_ORDER = 8;

  localparam logic [1:0] FUNC_COEF  = 2'd0;
  localparam logic [1:0] FUNC_GUESS = 2'd1;
  localparam logic [1:0] FUNC_SOLVE = 2'd2;
  localparam logic [1:0] ST_CONV = 2'd0;
  localparam logic [1:0] ST_ZDIAG = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;
  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_ROWINIT, S_MAC, S_MACW, S_DIV, S_DIVW, S_UPD, S_EMIT
  } gsls_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic solve_init;   // clear sweep count and result index
    logic sweep_start;  // clear changed flag, count sweep
    logic row_init;     // point j at 0, latch the diagonal
    logic mac_rd;       // issue reads for a[i][j], x[j]
    logic mac_acc;      // load sum from b[i]*2^16
    logic div_start;
    logic upd;          // write x[i], update flag
    logic next_row;
    logic emit_rd;      // read x[k]
    logic emit_next;
  } gsls_cmd_t;

  typedef struct packed {
    logic j_done;
    logic diag_zero;
    logic div_done;
    logic row_last;
    logic changed;
    logic limit_hit;
  } gsls_sts_t;
endpackage

// ===== hw/rtl/gsls_div.sv =====
// Radix-2 restoring divider: 64-bit signed numerator by 16-bit signed divisor.
// Truncates toward zero and saturates to 32 bits. Depends on nothing.
module gsls_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [15:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d;
  logic [15:0] den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [16:0] trial;
  logic [63:0] qs;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q; trial = '0;
    done_o = 1'b0;
    if (start_i) begin
      quo_d = num_i[63] ? 64'(-num_i) : num_i;
      den_d = den_i[15] ? 16'(-den_i) : den_i;
      neg_d = num_i[63] ^ den_i[15];
      rem_d = '0; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != 7'd0) begin
        // The partial remainder stays below the divisor, so 17 bits suffice.
        trial = {rem_q[15:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
        if (trial >= {1'b0, den_q}) begin
          trial = trial - {1'b0, den_q};
          quo_d[0] = 1'b1;
        end
        rem_d = {47'd0, trial};
        cnt_d = cnt_q - 7'd1;
      end else begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_comb begin
    qs = neg_q ? 64'(-quo_q) : quo_q;
    if (!neg_q && quo_q > 64'h7FFF_FFFF) quo_o = 32'sh7FFF_FFFF;
    else if (neg_q && quo_q > 64'h8000_0000) quo_o = -32'sh7FFF_FFFF - 32'sd1;
    else quo_o = qs[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end
endmodule

// ===== hw/rtl/gsls_datapath.sv =====
// Datapath: coefficient and estimate memories, multiply-accumulate, divider.
// Depends on gsls_pkg and gsls_div.
module gsls_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               coef_we_i,
  input  logic               guess_we_i,
  input  logic [2:0]         row_i,
  input  logic [3:0]         col_i,
  input  logic signed [15:0] coef_i,
  input  logic signed [31:0] guess_i,
  input  logic [3:0]         order_i,
  input  logic [15:0]        tol_i,
  input  logic [5:0]         limit_i,
  input  gsls_pkg::gsls_cmd_t cmd_i,
  output gsls_pkg::gsls_sts_t sts_o,
  output logic [2:0]         k_o,
  output logic signed [31:0] x_o
);
  localparam int MAX_ORDER = gsls_pkg::MAX_ORDER;
  localparam int IW = $clog2(MAX_ORDER);
  localparam int CW = $clog2(MAX_ORDER + 1);
  localparam int AD = MAX_ORDER * (MAX_ORDER + 1);
  localparam int AW = $clog2(AD);

  logic signed [15:0] amem [AD];
  logic signed [31:0] xmem [MAX_ORDER];
  logic signed [15:0] a_rd_q, diag_q;
  logic signed [31:0] x_rd_q, xold_q;
  logic signed [47:0] prod_q;
  logic signed [63:0] sum_q;
  logic [IW-1:0] i_q, k_q;
  logic [CW-1:0] j_q, n_c;
  logic [5:0]    sweep_q;
  logic          chg_q, acc_v_q, skip_q, acc_v2_q, skip2_q;
  logic          div_done;
  logic signed [31:0] quo;
  logic signed [32:0] delta;
  logic [32:0]   adelta;
  logic [AW-1:0] wa, ra;
  logic [CW-1:0] col_c;
  logic [IW:0]   row_ext;

  always_comb begin
    if (order_i == 4'd0) n_c = CW'(1);
    else if ({28'd0, order_i} > MAX_ORDER) n_c = CW'(MAX_ORDER);
    else n_c = CW'(order_i);
  end

  assign col_c = CW'(col_i);
  assign row_ext = (IW + 1)'(row_i);
  assign wa = AW'(row_i) * AW'(MAX_ORDER + 1) + AW'(col_i);
  assign ra = cmd_i.mac_rd ? AW'(i_q) * AW'(MAX_ORDER + 1) + AW'(j_q)
                           : AW'(i_q) * AW'(MAX_ORDER + 1) + AW'(n_c);

  always_ff @(posedge clk_i) begin
    if (coef_we_i && {1'b0, row_i} < 4'(MAX_ORDER) && {28'd0, col_i} <= MAX_ORDER &&
        row_ext < (IW + 1)'(MAX_ORDER) && col_c <= CW'(MAX_ORDER))
      amem[wa] <= coef_i;
    if (guess_we_i && {1'b0, row_i} < 4'(MAX_ORDER))
      xmem[IW'(row_i)] <= guess_i;
    else if (cmd_i.upd)
      xmem[i_q] <= quo;
    a_rd_q <= amem[ra];
    x_rd_q <= xmem[cmd_i.emit_rd ? k_q : (cmd_i.mac_rd ? IW'(j_q) : i_q)];
    if (cmd_i.row_init) diag_q <= amem[AW'(i_q) * AW'(MAX_ORDER + 1) + AW'(i_q)];
    prod_q <= a_rd_q * x_rd_q;
  end

  // Read of b[i] (in a_rd_q) happens in row_init's cycle; sum starts from b*2^16.
  // A product reaches the sum through the read and product registers, so the valid
  // and skip marks travel through two stages beside the read and product registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0; j_q <= '0; k_q <= '0; sweep_q <= '0; chg_q <= 1'b0;
      acc_v_q <= 1'b0; skip_q <= 1'b0; acc_v2_q <= 1'b0; skip2_q <= 1'b0;
      sum_q <= '0; xold_q <= '0;
    end else begin
      acc_v_q <= cmd_i.mac_rd;
      skip_q <= (j_q == CW'(i_q));
      acc_v2_q <= acc_v_q;
      skip2_q <= skip_q;
      if (cmd_i.solve_init) begin
        sweep_q <= '0;
        k_q <= '0;
      end
      if (cmd_i.sweep_start) begin
        chg_q <= 1'b0;
        sweep_q <= sweep_q + 6'd1;
        i_q <= '0;
      end
      if (cmd_i.row_init) j_q <= '0;
      if (cmd_i.mac_rd) j_q <= j_q + CW'(1);
      if (cmd_i.mac_acc) sum_q <= {{32{a_rd_q[15]}}, a_rd_q, 16'd0};
      else if (acc_v2_q && !skip2_q) sum_q <= sum_q - 64'(prod_q);
      if (cmd_i.upd) begin
        if (adelta > {17'd0, tol_i} && sweep_q < limit_i) chg_q <= 1'b1;
      end
      if (cmd_i.next_row) i_q <= i_q + IW'(1);
      if (cmd_i.emit_next) k_q <= k_q + IW'(1);
      if (cmd_i.div_start) xold_q <= x_rd_q;
    end
  end

  gsls_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(sum_q), .den_i(diag_q),
    .done_o(div_done), .quo_o(quo)
  );

  assign delta = 33'(xold_q) - 33'(quo);
  assign adelta = delta[32] ? 33'(-delta) : delta;

  assign sts_o.j_done = (j_q == n_c);
  assign sts_o.diag_zero = (diag_q == 16'sd0);
  assign sts_o.div_done = div_done;
  assign sts_o.row_last = (CW'(i_q) == n_c - CW'(1));
  assign sts_o.changed = chg_q;
  assign sts_o.limit_hit = (sweep_q >= limit_i);
  assign k_o = 3'(k_q);
  assign x_o = x_rd_q;
endmodule

// ===== hw/rtl/gsls_ctrl.sv =====
// Controller state machine sequencing sweeps, rows and result emission.
// Depends on gsls_pkg.
module gsls_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic solve_i,
  input  logic out_ready_i,
  input  logic [3:0] n_i,
  input  logic [2:0] k_i,
  input  gsls_pkg::gsls_sts_t sts_i,
  output gsls_pkg::gsls_cmd_t cmd_o,
  output logic busy_o,
  output logic out_load_o,
  output logic [1:0] status_o,
  output logic last_o
);
  gsls_pkg::gsls_state_e state_q, state_d;
  logic [1:0] stat_q, stat_d;
  logic       pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsls_pkg::S_IDLE;
      stat_q <= gsls_pkg::ST_CONV;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stat_q <= stat_d;
      pend_q <= pend_d;
    end
  end

  always_comb begin
    state_d = state_q; stat_d = stat_q; pend_d = 1'b0;
    cmd_o = '0; out_load_o = 1'b0;
    case (state_q)
      gsls_pkg::S_IDLE: begin
        if (solve_i) begin
          cmd_o.solve_init = 1'b1;
          state_d = gsls_pkg::S_SWEEP;
        end
      end
      gsls_pkg::S_SWEEP: begin
        cmd_o.sweep_start = 1'b1;
        state_d = gsls_pkg::S_ROWINIT;
      end
      gsls_pkg::S_ROWINIT: begin
        // Reads b[i] and the diagonal; sum loads from b next cycle.
        cmd_o.row_init = 1'b1;
        state_d = gsls_pkg::S_MAC;
      end
      gsls_pkg::S_MAC: begin
        if (!pend_q) cmd_o.mac_acc = 1'b1;
        if (sts_i.diag_zero) begin
          stat_d = gsls_pkg::ST_ZDIAG;
          state_d = gsls_pkg::S_EMIT;
        end else if (!sts_i.j_done) begin
          cmd_o.mac_rd = 1'b1;
          pend_d = 1'b1;
        end else state_d = gsls_pkg::S_MACW;
      end
      gsls_pkg::S_MACW: begin
        // Drains the read and product registers into the sum.
        pend_d = pend_q;
        if (pend_q) begin
          state_d = gsls_pkg::S_DIV;
          pend_d = 1'b0;
        end else pend_d = 1'b1;
      end
      gsls_pkg::S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = gsls_pkg::S_DIVW;
      end
      gsls_pkg::S_DIVW: if (sts_i.div_done) state_d = gsls_pkg::S_UPD;
      gsls_pkg::S_UPD: begin
        cmd_o.upd = 1'b1;
        if (!sts_i.row_last) begin
          cmd_o.next_row = 1'b1;
          state_d = gsls_pkg::S_ROWINIT;
        end else state_d = gsls_pkg::S_UPD;
        if (sts_i.row_last) begin
          cmd_o.upd = 1'b1;
          state_d = gsls_pkg::S_EMIT;
          pend_d = 1'b0;
          stat_d = gsls_pkg::ST_CONV;
        end
      end
      gsls_pkg::S_EMIT: begin
        // First cycle after the last row decides whether to sweep again.
        if (!pend_q && stat_q == gsls_pkg::ST_CONV && sts_i.changed && !sts_i.limit_hit) begin
          state_d = gsls_pkg::S_SWEEP;
        end else begin
          if (!pend_q && stat_q == gsls_pkg::ST_CONV && sts_i.limit_hit)
            stat_d = gsls_pkg::ST_LIMIT;
          // Each result is read into the read register and handed to the output
          // register in a later cycle; the read repeats while the output is full.
          cmd_o.emit_rd = 1'b1;
          pend_d = 1'b1;
          if (pend_q && out_ready_i) begin
            out_load_o = 1'b1;
            cmd_o.emit_next = 1'b1;
            pend_d = 1'b0;
            if ({1'b0, k_i} + 4'd1 == n_i) state_d = gsls_pkg::S_IDLE;
          end
        end
      end
      default: state_d = gsls_pkg::S_IDLE;
    endcase
  end

  assign busy_o = (state_q != gsls_pkg::S_IDLE);
  assign status_o = stat_q;
  assign last_o = ({1'b0, k_i} + 4'd1 == n_i);
endmodule

// ===== hw/rtl/gauss_seidel_linear_solver_top.sv =====
// Gauss-Seidel solver. Load items are accepted while the block is idle. A solve
// holds the input off; for n unknowns each sweep runs through the n rows, each row
// with reads and accumulation, then the 64-step divider, then one update. The n
// results then leave in index order through one output register, each read from
// the estimate memory before it is loaded there. Reset clears control state and
// sets configuration defaults; matrix and estimates are undefined until loaded.
module gauss_seidel_linear_solver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: row[2:0], col[6:3], coef_value[22:7], guess_value[54:23]
  input  logic [55:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: unknown_index[2:0], solution_value[34:3]
  output logic [39:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic [3:0]  order_q;
  logic [15:0] tol_q;
  logic [5:0]  limit_q;
  logic        busy, out_load, last, acc;
  logic [1:0]  status;
  logic [2:0]  k;
  logic signed [31:0] x;
  logic [3:0]  n;
  gsls_pkg::gsls_cmd_t cmd;
  gsls_pkg::gsls_sts_t sts;
  logic        ov_q;
  logic [39:0] od_q;
  logic [1:0]  ou_q;
  logic        ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 4'd1; tol_q <= 16'd66; limit_q <= 6'd30;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gsls_pkg::REG_ORDER: order_q <= cfg_data_i[3:0];
        gsls_pkg::REG_TOL:   tol_q <= cfg_data_i;
        gsls_pkg::REG_LIMIT: limit_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (order_q == 4'd0) n = 4'd1;
    else if ({28'd0, order_q} > gsls_pkg::MAX_ORDER) n = 4'(gsls_pkg::MAX_ORDER);
    else n = order_q;
  end

  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;

  gsls_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .solve_i(acc && s_axis_tuser == gsls_pkg::FUNC_SOLVE),
    .out_ready_i(!ov_q || m_axis_tready), .n_i(n), .k_i(k), .sts_i(sts),
    .cmd_o(cmd), .busy_o(busy), .out_load_o(out_load), .status_o(status), .last_o(last)
  );

  gsls_datapath u_dp (
    .clk_i, .rst_ni,
    .coef_we_i(acc && s_axis_tuser == gsls_pkg::FUNC_COEF),
    .guess_we_i(acc && s_axis_tuser == gsls_pkg::FUNC_GUESS),
    .row_i(s_axis_tdata[2:0]), .col_i(s_axis_tdata[6:3]),
    .coef_i(s_axis_tdata[22:7]), .guess_i(s_axis_tdata[54:23]),
    .order_i(order_q), .tol_i(tol_q), .limit_i(limit_q),
    .cmd_i(cmd), .sts_o(sts), .k_o(k), .x_o(x)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (out_load) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      od_q <= {5'd0, x, k};
      ou_q <= status;
      ol_q <= last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign m_axis_tuser = ou_q;
  assign m_axis_tlast = ol_q;
endmodule

// ===== hw/rtl/gsls_checker.sv =====
// Port-level checker for the solver, bound to the top level.
// Depends on gauss_seidel_linear_solver_top_defines.svh.
`include "gauss_seidel_linear_solver_top_defines.svh"
module gsls_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);
  // No input is taken while results are still being produced.
  `GS_ASSERT_IMP(a_busy_out, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)
  `GS_ASSERT_IMP(a_status, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser != 2'd3)
  // A stalled result stays valid with its status held.
  `GS_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tuser))
endmodule

bind gauss_seidel_linear_solver_top gsls_port_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tuser, .m_axis_tlast
);

// ===== tb/gsls_checker.sv =====
// Checker for the Gauss-Seidel solver: predicts each solve from the loads and
// register writes it observes and compares every result transfer. Uses gsls_pkg.
`timescale 1ns / 100ps

module gsls_checker
  import gsls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [55:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  typedef struct {
    logic [2:0]  index;
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;
  } solution_t;

  logic signed [15:0] coef_mem [8][9];
  logic signed [31:0] estimate_mem [8];
  logic [3:0]  order_q;
  logic [15:0] tol_q;
  logic [5:0]  limit_q;
  solution_t   solutions_due [$];

  // In-place sweeps over the first n unknowns; returns the solve status.
  function automatic logic [1:0] run_sweeps(int n);
    int sweeps;
    bit moved;
    longint acc, diag, num, quot, delta;
    logic signed [31:0] upd;
    sweeps = 0;
    do begin
      moved = 0;
      sweeps = (sweeps + 1) & 63;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++)
          if (j != i) acc += longint'(coef_mem[i][j]) * longint'(estimate_mem[j]);
        diag = longint'(coef_mem[i][i]);
        if (diag == 0) return ST_ZDIAG;
        num = longint'(coef_mem[i][n]) * 65536 - acc;
        quot = num / diag;
        if (quot > 64'sd2147483647) upd = 32'h7fffffff;
        else if (quot < -64'sd2147483648) upd = 32'h80000000;
        else upd = quot[31:0];
        delta = longint'(estimate_mem[i]) - longint'(upd);
        if (delta < 0) delta = -delta;
        if (delta > longint'(tol_q) && sweeps < int'(limit_q)) moved = 1;
        estimate_mem[i] = upd;
      end
    end while (moved);
    return (sweeps < int'(limit_q)) ? ST_CONV : ST_LIMIT;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count_o < 40)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [1:0]  func;
    logic [2:0]  row;
    logic [3:0]  col;
    logic [1:0]  st;
    int          n;
    solution_t   s;
    if (!rst_ni) begin
      order_q = 4'd1;
      tol_q = 16'd66;
      limit_q = 6'd30;
      solutions_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ORDER: order_q = cfg_data_i[3:0];
          REG_TOL:   tol_q = cfg_data_i;
          REG_LIMIT: limit_q = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (solutions_due.size() == 0) begin
          report_mismatch("unexpected result", m_tdata_i[31:0], '0);
        end else begin
          s = solutions_due.pop_front();
          if (m_tdata_i[2:0] !== s.index) report_mismatch("index", m_tdata_i[2:0], s.index);
          if (m_tdata_i[34:3] !== s.value) report_mismatch("value", m_tdata_i[34:3], s.value);
          if (m_tuser_i !== s.status) report_mismatch("status", m_tuser_i, s.status);
          if (m_tlast_i !== s.last) report_mismatch("last", m_tlast_i, s.last);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        func = s_tuser_i;
        row = s_tdata_i[2:0];
        col = s_tdata_i[6:3];
        if (func == FUNC_COEF) begin
          if (col <= 4'd8) coef_mem[row][col] = s_tdata_i[22:7];
        end else if (func == FUNC_GUESS) begin
          estimate_mem[row] = s_tdata_i[54:23];
        end else if (func == FUNC_SOLVE) begin
          n = (order_q == 0) ? 1 : (order_q > 8) ? 8 : int'(order_q);
          st = run_sweeps(n);
          for (int k = 0; k < n; k++) begin
            s.index = k[2:0];
            s.value = estimate_mem[k];
            s.status = st;
            s.last = (k == n - 1);
            solutions_due.push_back(s);
          end
        end
      end
    end
    pending_o = solutions_due.size();
  end
endmodule

// ===== tb/tb.sv =====
// Top of the solver testbench: clock, reset, load/solve stimulus with random
// idling and receiver stalls, and the verdict. Needs gsls_checker and gsls_pkg.
`timescale 1ns / 100ps

module tb;
  import gsls_pkg::*;

  localparam int RANDOM_ITEMS = 410;
  localparam int CYCLE_LIMIT = 5000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  int fail_count, pending, cycle_count, items_sent, burst_left, hold_cycles;
  int rx_mode, rx_left;

  always #5 clk_i = ~clk_i;

  gauss_seidel_linear_solver_top DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  gsls_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser), .m_tlast_i(m_axis_tlast),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, otherwise a changing stall pattern.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 9) != 0);
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Offers one item and returns in the step of its transfer.
  task automatic send_item(logic [1:0] func, logic [2:0] row, logic [3:0] col,
                           logic [15:0] coef, logic [31:0] guess);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {1'b0, guess, coef, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic load_coef(int row, int col, logic [15:0] v);
    send_item(FUNC_COEF, row[2:0], col[3:0], v, $urandom);
  endtask

  task automatic load_guess(int row, logic [31:0] v);
    send_item(FUNC_GUESS, row[2:0], 4'($urandom), 16'($urandom), v);
  endtask

  task automatic start_solve();
    send_item(FUNC_SOLVE, 3'($urandom), 4'($urandom), 16'($urandom), $urandom);
  endtask

  // Waits until every result is back and the block has gone quiet.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_registers(logic [15:0] order, logic [15:0] tol, logic [15:0] limit);
    logic [1:0]  idx [3];
    logic [15:0] val [3];
    idx = '{REG_ORDER, REG_TOL, REG_LIMIT};
    val = '{order, tol, limit};
    for (int k = 0; k < 3; k++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Loads a full system of order n, mostly diagonally dominant so it settles.
  task automatic load_system(int n);
    int spread, sum, a, d;
    bit wild;
    wild = ($urandom_range(0, 6) == 0);
    spread = ($urandom_range(0, 2) == 0) ? 1 : ($urandom_range(0, 1) ? 100 : 4000);
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        a = wild ? int'($signed(16'($urandom))) : $urandom_range(0, 2 * spread) - spread;
        sum += (a < 0) ? -a : a;
        load_coef(i, j, a[15:0]);
      end
      d = sum + $urandom_range(1, 200);
      if (d > 32767) d = 32767;
      if ($urandom_range(0, 1)) d = -d;
      if (wild) d = int'($signed(16'($urandom)));
      load_coef(i, i, d[15:0]);
      load_coef(i, n, 16'($urandom));
    end
    for (int i = 0; i < n; i++)
      load_guess(i, $urandom_range(0, 2) == 0 ? $urandom : 32'($urandom_range(0, 1 << 20)));
  endtask

  initial begin
    int n, edits, order_raw, phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, saturation, one-sweep limit, ignored items, zero diagonal.
    set_registers(16'd2, 16'd0, 16'd1);
    load_coef(0, 0, 16'd1);
    load_coef(0, 1, 16'h8000);
    load_coef(0, 2, 16'h7fff);
    load_coef(1, 0, 16'd0);
    load_coef(1, 1, 16'hffff);
    load_coef(1, 2, 16'h8000);
    load_guess(0, 32'h7fffffff);
    load_guess(1, 32'h80000000);
    start_solve();
    send_item(2'd3, 3'd7, 4'd15, 16'hffff, 32'hffffffff);
    load_coef(7, 12, 16'h1234);
    start_solve();
    load_coef(1, 1, 16'd0);
    start_solve();
    drain();
    set_registers(16'd0, 16'hffff, 16'd63);
    load_coef(0, 0, 16'h8000);
    start_solve();
    drain();

    // Random phases, each with its own register setting and a fresh system.
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase % 5)
        0: order_raw = 8;
        1: order_raw = 1;
        2: order_raw = $urandom_range(9, 15);
        default: order_raw = $urandom_range(1, 8);
      endcase
      n = (order_raw > 8) ? 8 : order_raw;
      if (n > 4 && phase % 5 != 0 && phase % 5 != 2) n = $urandom_range(1, 4);
      if (order_raw <= 8) order_raw = n;
      set_registers(order_raw[15:0],
                    $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200)),
                    $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 63))
                                              : 16'($urandom_range(5, 20)));
      load_system(n);
      repeat ($urandom_range(1, 4)) begin
        start_solve();
        if (phase == 1) hold_cycles = 3000;
        edits = $urandom_range(0, 5);
        repeat (edits) begin
          case ($urandom_range(0, 4))
            0: load_coef($urandom_range(0, n - 1), $urandom_range(0, n),
                         16'($urandom_range(0, 400)) - 16'd200);
            1: load_guess($urandom_range(0, n - 1), $urandom);
            2: send_item(2'd3, 3'($urandom), 4'($urandom), 16'($urandom), $urandom);
            3: load_coef($urandom_range(0, 7), $urandom_range(9, 15), 16'($urandom));
            default: load_coef($urandom_range(n, 7), $urandom_range(0, 8), 16'($urandom));
          endcase
        end
      end
      drain();
      phase++;
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
